// ===== rtl/bps_pkg.sv =====
// ---------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the baud prescaler search block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned DIV_CNT_W  = $clog2(DATA_W);
  localparam logic [DATA_W-1:0] BUS_CLOCK_RST = 32'd25000000;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } bps_state_e;

  // Divider response: quotient valid when done is high, held until the next start
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } bps_div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bps_divider.sv =====
// ---------------------------------------------------------------------------
// bps_divider
// Restoring divider, one quotient bit per cycle, for a narrow divisor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bps_divider
  import bps_pkg::*;
#(
  parameter int unsigned DIVISOR_W = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DATA_W-1:0]    dividend_i,
  input  wire logic [DIVISOR_W-1:0] divisor_i,
  output bps_div_rsp_t              rsp_o
);

  localparam int unsigned REM_W = DIVISOR_W + 1;

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIVISOR_W-1:0] dvs_q, dvs_d;
  logic [REM_W-1:0]     rem_shift;
  logic                 fits;

  assign rem_shift = {rem_q[REM_W-2:0], quo_q[DATA_W-1]};
  assign fits      = rem_shift >= REM_W'(dvs_q);

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      quo_d = {quo_q[DATA_W-2:0], fits};
      rem_d = fits ? (rem_shift - REM_W'(dvs_q)) : rem_shift;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/baud_prescaler_search_top.sv =====
// ---------------------------------------------------------------------------
// baud_prescaler_search_top
// Finds the prescaler / power-of-two pair whose serial rate is closest to
// the requested rate for the configured bus clock.
// ---------------------------------------------------------------------------
// Channel   Direction  Signals                                 Transfer
// request   in         start_i, target_rate_i, busy_o          start_i & !busy_o
// result    out        done_o, linear_prescale_o,              done_o (one cycle)
//                      power_select_o, rate_error_o
// config    in         cfg_we_i, cfg_data_i                    cfg_we_i
//
// Per linear prescaler code: a start pulse to the divider, a bit-serial
// division of the bus clock by the code plus one, loading of the quotient,
// then a scan over the POWER_MAX+1 power codes; an exact match ends the
// search earlier.
// Reset loads bus_clock_q with 25 MHz and returns the sequencer to idle.
// The result strobe cannot be stalled; busy_o is low again the cycle after.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module baud_prescaler_search_top
  import bps_pkg::*;
#(
  parameter int unsigned LINEAR_MAX = 7,
  parameter int unsigned POWER_MAX  = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [DATA_W-1:0] cfg_data_i,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] target_rate_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [CODE_W-1:0]      linear_prescale_o,
  output logic [CODE_W-1:0]      power_select_o,
  output logic [DATA_W-1:0]      rate_error_o
);

  localparam int unsigned LPW   = $clog2(LINEAR_MAX + 1);
  localparam int unsigned SPW   = $clog2(POWER_MAX + 1);
  localparam int unsigned DVS_W = $clog2(LINEAR_MAX + 2);

  bps_state_e        state_q, state_d;
  logic [DATA_W-1:0] bus_clock_q;
  logic [DATA_W-1:0] target_q, target_d;
  logic [LPW-1:0]    p_q, p_d;
  logic [SPW-1:0]    s_q, s_d;
  logic [DATA_W-1:0] rate_q, rate_d;
  logic [DATA_W-1:0] best_err_q, best_err_d;
  logic [LPW-1:0]    best_p_q, best_p_d;
  logic [SPW-1:0]    best_s_q, best_s_d;
  logic              first_q, first_d;
  logic              div_start_q, div_start_d;
  logic [DATA_W-1:0] err;
  logic [LPW+CODE_W-1:0] p_ext;
  logic [SPW+CODE_W-1:0] s_ext;
  bps_div_rsp_t      div_rsp;

  bps_divider #(
    .DIVISOR_W(DVS_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(bus_clock_q),
    .divisor_i (DVS_W'(p_q) + DVS_W'(1)),
    .rsp_o     (div_rsp)
  );

  assign err = (rate_q >= target_q) ? (rate_q - target_q) : (target_q - rate_q);

  always_comb begin
    state_d     = state_q;
    target_d    = target_q;
    p_d         = p_q;
    s_d         = s_q;
    rate_d      = rate_q;
    best_err_d  = best_err_q;
    best_p_d    = best_p_q;
    best_s_d    = best_s_q;
    first_d     = first_q;
    div_start_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          target_d    = target_rate_i;
          p_d         = '0;
          first_d     = 1'b1;
          div_start_d = 1'b1;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          // bus / ((p+1) * 2^(s+1)) == (bus / (p+1)) >> (s+1)
          rate_d  = div_rsp.quotient >> 1;
          s_d     = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (first_q || (err < best_err_q)) begin
          best_err_d = err;
          best_p_d   = p_q;
          best_s_d   = s_q;
        end
        first_d = 1'b0;
        rate_d  = rate_q >> 1;
        s_d     = s_q + 1'b1;
        priority if (err == '0) begin
          state_d = ST_DONE;
        end else if (s_q == SPW'(POWER_MAX)) begin
          if (p_q == LPW'(LINEAR_MAX)) begin
            state_d = ST_DONE;
          end else begin
            p_d         = p_q + 1'b1;
            div_start_d = 1'b1;
            state_d     = ST_DIV;
          end
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bus_clock_q <= BUS_CLOCK_RST;
      first_q     <= 1'b1;
      div_start_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      div_start_q <= div_start_d;
      if (cfg_we_i) begin
        bus_clock_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    target_q   <= target_d;
    p_q        <= p_d;
    s_q        <= s_d;
    rate_q     <= rate_d;
    best_err_q <= best_err_d;
    best_p_q   <= best_p_d;
    best_s_q   <= best_s_d;
  end

  assign p_ext = (LPW + CODE_W)'(best_p_q);
  assign s_ext = (SPW + CODE_W)'(best_s_q);

  assign busy_o            = (state_q != ST_IDLE);
  assign done_o            = (state_q == ST_DONE);
  assign linear_prescale_o = p_ext[CODE_W-1:0];
  assign power_select_o    = s_ext[CODE_W-1:0];
  assign rate_error_o      = best_err_q;

endmodule

`default_nettype wire

// ===== rtl/bps_checker.sv =====
// ---------------------------------------------------------------------------
// bps_checker
// Port-level checks on the search block's request/result sequencing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bps_checker
  import bps_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire logic              done_o,
  input wire logic [DATA_W-1:0] rate_error_o
);

  // a result only appears while a request is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe while idle");

  // an accepted request makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request transfer did not raise busy");

  // after the result the block frees up at once
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("still busy after result");

  // the result strobe does not repeat back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("repeated result strobe");

  // the reported error does not move while the block stays idle
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && $past(!busy_o) && $past(rst_ni)) |-> $stable(rate_error_o))
    else $error("rate error changed while idle");

endmodule

bind baud_prescaler_search_top bps_checker u_bps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .rate_error_o(rate_error_o)
);

`default_nettype wire
